// ===== rtl/ccpp_pkg.sv =====
// Package for the constant-pool parser: phase codes, tag codes, record type
// and the tag layout function. No dependencies.
`timescale 1ns / 1ps

package ccpp_pkg;

  typedef enum logic [1:0] {
    PH_TAG    = 2'd0,
    PH_FIELDS = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  localparam logic [7:0] TAG_UTF8       = 8'd1;
  localparam logic [7:0] TAG_INTEGER    = 8'd3;
  localparam logic [7:0] TAG_FLOAT      = 8'd4;
  localparam logic [7:0] TAG_LONG       = 8'd5;
  localparam logic [7:0] TAG_DOUBLE     = 8'd6;
  localparam logic [7:0] TAG_CLASS      = 8'd7;
  localparam logic [7:0] TAG_STRING     = 8'd8;
  localparam logic [7:0] TAG_FIELDREF   = 8'd9;
  localparam logic [7:0] TAG_METHODREF  = 8'd10;
  localparam logic [7:0] TAG_IFMETHREF  = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE   = 8'd12;
  localparam logic [7:0] TAG_METHHANDLE = 8'd15;
  localparam logic [7:0] TAG_METHTYPE   = 8'd16;
  localparam logic [7:0] TAG_INVOKEDYN  = 8'd18;

  // Field byte count of a tag and how many of them feed the first value.
  typedef struct packed {
    logic       known;
    logic [3:0] total;
    logic [2:0] split;
  } layout_t;

  // One result record.
  typedef struct packed {
    logic [15:0] slot_index;
    logic [7:0]  entry_tag;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        entry_done;
    logic        unknown_tag;
    logic        pool_last;
  } res_t;

  function automatic layout_t tag_layout(input logic [7:0] tag);
    layout_t lay;
    lay = '{known: 1'b1, total: 4'd2, split: 3'd2};
    case (tag)
      TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHTYPE: begin
        lay.total = 4'd2;
        lay.split = 3'd2;
      end
      TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHREF, TAG_NAMETYPE, TAG_INVOKEDYN: begin
        lay.total = 4'd4;
        lay.split = 3'd2;
      end
      TAG_INTEGER, TAG_FLOAT: begin
        lay.total = 4'd4;
        lay.split = 3'd4;
      end
      TAG_LONG, TAG_DOUBLE: begin
        lay.total = 4'd8;
        lay.split = 3'd4;
      end
      TAG_METHHANDLE: begin
        lay.total = 4'd3;
        lay.split = 3'd1;
      end
      default: begin
        lay.known = 1'b0;
      end
    endcase
    return lay;
  endfunction

endpackage

// ===== rtl/class_constant_pool_parser.sv =====
// Top level of the class-file constant-pool parser.
// Uses ccpp_pkg, ccpp_in_stage, ccpp_parse and ccpp_out_stage.
`timescale 1ns / 1ps
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------------
//  in       | in_valid_i / in_stall_o         | in_byte_i
//  out      | out_valid_o / out_stall_i       | slot_index_o .. pool_last_o
//  config   | cfg_we_i (no wait, no readback) | cfg_data_i = pool_count
//
//  One byte per cycle sustained while out_stall_i is low. A byte is held in
//  the input register, is parsed by the step logic against the parse
//  state, and its record (if any) sits in the result register from the
//  next cycle on. A stalled result register holds the byte in the input
//  register; the input then stalls only while that byte waits.
//  Reset (async, active low) sets pool_count to 1, so every byte is ignored
//  until pool_count is written; a write also restarts the parse at slot 1.

module class_constant_pool_parser
  import ccpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] slot_index_o,
  output logic [7:0]  entry_tag_o,
  output logic [31:0] first_value_o,
  output logic [31:0] second_value_o,
  output logic [7:0]  data_byte_o,
  output logic        data_valid_o,
  output logic        entry_done_o,
  output logic        unknown_tag_o,
  output logic        pool_last_o
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       out_free;
  logic       fire;
  logic       res_valid;
  res_t       res_next;
  res_t       res_cur;

  // The held byte is parsed once the result register can take its record.
  assign fire = hold_valid & out_free;

  ccpp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .fire_i       (fire),
    .in_stall_o   (in_stall_o),
    .hold_valid_o (hold_valid),
    .hold_byte_o  (hold_byte)
  );

  ccpp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (fire),
    .byte_i      (hold_byte),
    .res_valid_o (res_valid),
    .res_o       (res_next)
  );

  ccpp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire & res_valid),
    .res_i       (res_next),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .res_o       (res_cur)
  );

  assign slot_index_o   = res_cur.slot_index;
  assign entry_tag_o    = res_cur.entry_tag;
  assign first_value_o  = res_cur.first_value;
  assign second_value_o = res_cur.second_value;
  assign data_byte_o    = res_cur.data_byte;
  assign data_valid_o   = res_cur.data_valid;
  assign entry_done_o   = res_cur.entry_done;
  assign unknown_tag_o  = res_cur.unknown_tag;
  assign pool_last_o    = res_cur.pool_last;

endmodule

// ===== rtl/ccpp_in_stage.sv =====
// Input register of the constant-pool parser: holds one stream byte.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module ccpp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       fire_i,
  output logic       in_stall_o,
  output logic       hold_valid_o,
  output logic [7:0] hold_byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       accept;

  // Free when empty or when the held byte moves on this cycle.
  assign in_stall_o = valid_q & ~fire_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (fire_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

  assign hold_valid_o = valid_q;
  assign hold_byte_o  = byte_q;

endmodule

// ===== rtl/ccpp_parse.sv =====
// Parse state and per-byte step logic of the constant-pool parser.
// Uses ccpp_pkg for phase codes, tag layout and the record type.
`timescale 1ns / 1ps

module ccpp_parse
  import ccpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] pool_count_q;
  logic [15:0] slot_q, slot_d;
  logic [7:0]  held_tag_q, held_tag_d;
  logic [2:0]  field_cnt_q, field_cnt_d;
  logic [31:0] first_acc_q, first_acc_d;
  logic [31:0] second_acc_q, second_acc_d;
  logic [15:0] body_left_q, body_left_d;
  logic        finished_q, finished_d;

  layout_t     lay_in, lay_held;
  logic        active;
  logic [2:0]  cnt_inc;
  logic        fields_done;
  logic        to_first;
  logic [31:0] first_new, second_new;
  logic        enter_body;
  logic [15:0] body_dec;
  logic        body_end;
  logic        wide;
  logic [16:0] slot_next;
  logic        is_last;

  assign lay_in   = tag_layout(byte_i);
  assign lay_held = tag_layout(held_tag_q);
  assign active   = ~finished_q & (slot_q < pool_count_q);

  assign cnt_inc     = field_cnt_q + 3'd1;
  assign fields_done = (cnt_inc == lay_held.total[2:0]);
  assign to_first    = (field_cnt_q < lay_held.split);
  assign first_new   = to_first ? {first_acc_q[23:0], byte_i} : first_acc_q;
  assign second_new  = to_first ? second_acc_q : {second_acc_q[23:0], byte_i};
  assign enter_body  = fields_done & (held_tag_q == TAG_UTF8) & (first_new[15:0] != 16'd0);

  assign body_dec = body_left_q - 16'd1;
  assign body_end = (body_dec == 16'd0);

  // Long and Double take two slots.
  assign wide      = (phase_q == PH_FIELDS) &
                     ((held_tag_q == TAG_LONG) | (held_tag_q == TAG_DOUBLE));
  assign slot_next = {1'b0, slot_q} + (wide ? 17'd2 : 17'd1);
  assign is_last   = (slot_next >= {1'b0, pool_count_q});

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (active) begin
      case (phase_q)
        PH_FIELDS: begin
          if (fields_done) begin
            phase_d = enter_body ? PH_BODY : PH_TAG;
          end
        end
        PH_BODY: begin
          if (body_end) begin
            phase_d = PH_TAG;
          end
        end
        default: begin
          phase_d = lay_in.known ? PH_FIELDS : PH_TAG;
        end
      endcase
    end
  end

  // Datapath and result.
  always_comb begin
    slot_d       = slot_q;
    held_tag_d   = held_tag_q;
    field_cnt_d  = field_cnt_q;
    first_acc_d  = first_acc_q;
    second_acc_d = second_acc_q;
    body_left_d  = body_left_q;
    finished_d   = finished_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    res_o.slot_index = slot_q;
    if (active) begin
      case (phase_q)
        PH_FIELDS: begin
          first_acc_d  = first_new;
          second_acc_d = second_new;
          field_cnt_d  = cnt_inc;
          if (enter_body) begin
            body_left_d = first_new[15:0];
            field_cnt_d = 3'd0;
          end else if (fields_done) begin
            res_valid_o        = 1'b1;
            res_o.entry_tag    = held_tag_q;
            res_o.first_value  = first_new;
            res_o.second_value = second_new;
            res_o.entry_done   = 1'b1;
            res_o.pool_last    = is_last;
          end
        end
        PH_BODY: begin
          body_left_d       = body_dec;
          res_valid_o       = 1'b1;
          res_o.entry_tag   = held_tag_q;
          res_o.first_value = first_acc_q;
          res_o.data_byte   = byte_i;
          res_o.data_valid  = 1'b1;
          res_o.entry_done  = body_end;
          res_o.pool_last   = body_end & is_last;
        end
        default: begin
          if (lay_in.known) begin
            held_tag_d   = byte_i;
            field_cnt_d  = 3'd0;
            first_acc_d  = '0;
            second_acc_d = '0;
          end else begin
            res_valid_o       = 1'b1;
            res_o.entry_tag   = byte_i;
            res_o.entry_done  = 1'b1;
            res_o.unknown_tag = 1'b1;
            res_o.pool_last   = is_last;
          end
        end
      endcase
      // Entry complete: move to the next slot and clear the entry state.
      if (res_valid_o && res_o.entry_done) begin
        slot_d       = slot_next[15:0];
        finished_d   = finished_q | is_last;
        held_tag_d   = '0;
        field_cnt_d  = '0;
        first_acc_d  = '0;
        second_acc_d = '0;
        body_left_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_count_q <= 16'd1;
      phase_q      <= PH_TAG;
      slot_q       <= 16'd1;
      held_tag_q   <= '0;
      field_cnt_q  <= '0;
      first_acc_q  <= '0;
      second_acc_q <= '0;
      body_left_q  <= '0;
      finished_q   <= 1'b0;
    end else if (cfg_we_i) begin
      pool_count_q <= cfg_data_i;
      phase_q      <= PH_TAG;
      slot_q       <= 16'd1;
      held_tag_q   <= '0;
      field_cnt_q  <= '0;
      first_acc_q  <= '0;
      second_acc_q <= '0;
      body_left_q  <= '0;
      finished_q   <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      slot_q       <= slot_d;
      held_tag_q   <= held_tag_d;
      field_cnt_q  <= field_cnt_d;
      first_acc_q  <= first_acc_d;
      second_acc_q <= second_acc_d;
      body_left_q  <= body_left_d;
      finished_q   <= finished_d;
    end
  end

endmodule

// ===== rtl/ccpp_out_stage.sv =====
// Result register of the constant-pool parser.
// Uses ccpp_pkg for the record type.
`timescale 1ns / 1ps

module ccpp_out_stage
  import ccpp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output logic free_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  // Room for a new record when empty or when the current one is taken.
  assign free_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/ccpp_checker.sv =====
// Port-level checks for the constant-pool parser, bound to the top level.
// Uses ccpp_pkg for tag codes; watches class_constant_pool_parser ports only.
`timescale 1ns / 1ps

module ccpp_checker
  import ccpp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] slot_index_o,
  input logic [7:0]  entry_tag_o,
  input logic [31:0] first_value_o,
  input logic [31:0] second_value_o,
  input logic [7:0]  data_byte_o,
  input logic        data_valid_o,
  input logic        entry_done_o,
  input logic        unknown_tag_o,
  input logic        pool_last_o
);

  // A stalled record holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_index_o)
      && $stable(first_value_o) && $stable(data_byte_o))
    else $error("stalled record changed");

  // Body bytes only belong to Utf8 entries.
  a_body_utf8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_valid_o |-> entry_tag_o == TAG_UTF8 && !unknown_tag_o)
    else $error("body byte on a non-Utf8 record");

  // Unknown tag: lone complete record with zero values.
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unknown_tag_o |-> entry_done_o && first_value_o == 32'd0
      && second_value_o == 32'd0 && !data_valid_o)
    else $error("bad unknown-tag record");

  // The final entry marker comes only on a completing record.
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pool_last_o |-> entry_done_o)
    else $error("pool_last without entry_done");

  // No body byte means a zero data byte.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_valid_o |-> data_byte_o == 8'd0)
    else $error("data_byte set without data_valid");

endmodule

bind class_constant_pool_parser ccpp_checker u_ccpp_checker (.*);

// ===== test/class_constant_pool_parser_test.sv =====
// Self-checking bench for class_constant_pool_parser: a directed table, then random
// constant-pool streams, checked against typed-in records and an in-bench parse model.
// Depends on ccpp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module class_constant_pool_parser_test;
  import ccpp_pkg::*;

  localparam int unsigned ITEM_GOAL    = 900;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;   // extra wait for stray records after the queue empties
  localparam int unsigned REPORT_MAX   = 10;

  // How a table row is used: a pool_count write, a byte whose outcome is typed in
  // (no result, or a fixed record), or a byte checked against the parse model.
  typedef enum {
    ROW_CFG,
    ROW_QUIET,
    ROW_FIXED,
    ROW_PREDICT
  } row_e;

  typedef struct {
    row_e        kind;
    logic [15:0] value;
    res_t        rec;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] slot_index_o;
  logic [7:0]  entry_tag_o;
  logic [31:0] first_value_o;
  logic [31:0] second_value_o;
  logic [7:0]  data_byte_o;
  logic        data_valid_o;
  logic        entry_done_o;
  logic        unknown_tag_o;
  logic        pool_last_o;

  class_constant_pool_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .slot_index_o   (slot_index_o),
    .entry_tag_o    (entry_tag_o),
    .first_value_o  (first_value_o),
    .second_value_o (second_value_o),
    .data_byte_o    (data_byte_o),
    .data_valid_o   (data_valid_o),
    .entry_done_o   (entry_done_o),
    .unknown_tag_o  (unknown_tag_o),
    .pool_last_o    (pool_last_o)
  );

  always #5 clk_i = ~clk_i;

  // Parse model state
  logic [15:0] pool_size;
  phase_e      pp_phase;
  logic [15:0] pp_slot;
  logic [7:0]  pp_tag;
  logic [2:0]  pp_count;
  logic [31:0] pp_first;
  logic [31:0] pp_second;
  logic [15:0] pp_left;
  bit          pp_done;

  res_t        awaited_records[$];
  bit          calm = 1'b0;     // no idling on either side while set
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned failures = 0;
  int unsigned records_checked = 0;
  int unsigned bytes_parsed = 0;
  int unsigned settings_used = 0;

  logic [7:0] known_tags [14] = '{
    TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE, TAG_CLASS, TAG_STRING,
    TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHREF, TAG_NAMETYPE, TAG_METHHANDLE,
    TAG_METHTYPE, TAG_INVOKEDYN
  };

  // Field bytes of a tag and how many of them build the first value.
  function automatic void entry_layout(input logic [7:0] tag, output bit known,
                                       output int unsigned total, output int unsigned split);
    known = 1'b1;
    case (tag)
      TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHTYPE: begin
        total = 2; split = 2;
      end
      TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHREF, TAG_NAMETYPE, TAG_INVOKEDYN: begin
        total = 4; split = 2;
      end
      TAG_INTEGER, TAG_FLOAT: begin
        total = 4; split = 4;
      end
      TAG_LONG, TAG_DOUBLE: begin
        total = 8; split = 4;
      end
      TAG_METHHANDLE: begin
        total = 3; split = 1;
      end
      default: begin
        known = 1'b0; total = 2; split = 2;
      end
    endcase
  endfunction

  task automatic restart_parse();
    pp_phase  = PH_TAG;
    pp_slot   = 16'd1;
    pp_tag    = '0;
    pp_count  = '0;
    pp_first  = '0;
    pp_second = '0;
    pp_left   = '0;
    pp_done   = 1'b0;
  endtask

  // Step past the entry; last is set when it fills the final slot.
  task automatic close_entry(input int unsigned width, output logic last);
    logic [16:0] nxt;
    nxt  = {1'b0, pp_slot} + 17'(width);
    last = (nxt >= {1'b0, pool_size});
    if (last) pp_done = 1'b1;
    pp_slot   = nxt[15:0];
    pp_phase  = PH_TAG;
    pp_tag    = '0;
    pp_count  = '0;
    pp_first  = '0;
    pp_second = '0;
    pp_left   = '0;
  endtask

  // One stream byte through the parse model; emitted marks a record.
  task automatic parse_byte(input logic [7:0] b, output bit emitted, output res_t rec);
    bit          known;
    int unsigned total;
    int unsigned split;
    logic        last;
    emitted = 1'b0;
    rec     = '0;
    if (pp_done || pp_slot >= pool_size) return;
    case (pp_phase)
      PH_FIELDS: begin
        entry_layout(pp_tag, known, total, split);
        if (pp_count < split) pp_first = {pp_first[23:0], b};
        else pp_second = {pp_second[23:0], b};
        pp_count = pp_count + 3'd1;
        // 3-bit count: a wide entry ends when it wraps to zero
        if (pp_count == total[2:0]) begin
          if (pp_tag == TAG_UTF8 && pp_first[15:0] != 16'd0) begin
            pp_left  = pp_first[15:0];
            pp_phase = PH_BODY;
            pp_count = '0;
          end else begin
            rec.slot_index   = pp_slot;
            rec.entry_tag    = pp_tag;
            rec.first_value  = pp_first;
            rec.second_value = pp_second;
            rec.entry_done   = 1'b1;
            close_entry((pp_tag == TAG_LONG || pp_tag == TAG_DOUBLE) ? 2 : 1, last);
            rec.pool_last = last;
            emitted = 1'b1;
          end
        end
      end
      PH_BODY: begin
        pp_left = pp_left - 16'd1;
        rec.slot_index  = pp_slot;
        rec.entry_tag   = pp_tag;
        rec.first_value = pp_first;
        rec.data_byte   = b;
        rec.data_valid  = 1'b1;
        emitted = 1'b1;
        if (pp_left == 16'd0) begin
          rec.entry_done = 1'b1;
          close_entry(1, last);
          rec.pool_last = last;
        end
      end
      default: begin
        // tag byte expected (also the unused phase code)
        entry_layout(b, known, total, split);
        if (known) begin
          pp_tag    = b;
          pp_phase  = PH_FIELDS;
          pp_count  = '0;
          pp_first  = '0;
          pp_second = '0;
        end else begin
          rec.slot_index  = pp_slot;
          rec.entry_tag   = b;
          rec.entry_done  = 1'b1;
          rec.unknown_tag = 1'b1;
          close_entry(1, last);
          rec.pool_last = last;
          emitted = 1'b1;
        end
      end
    endcase
  endtask

  function automatic res_t mk_rec(input logic [15:0] slot, input logic [7:0] tag,
                                  input logic [31:0] first, input logic [31:0] second,
                                  input logic done, input logic unk, input logic last);
    res_t r;
    r = '0;
    r.slot_index   = slot;
    r.entry_tag    = tag;
    r.first_value  = first;
    r.second_value = second;
    r.entry_done   = done;
    r.unknown_tag  = unk;
    r.pool_last    = last;
    return r;
  endfunction

  function automatic string fmt_rec(input res_t r);
    return $sformatf("slot %0d tag %0d first %h second %h data %h dv %b done %b unk %b last %b",
                     r.slot_index, r.entry_tag, r.first_value, r.second_value, r.data_byte,
                     r.data_valid, r.entry_done, r.unknown_tag, r.pool_last);
  endfunction

  function automatic string diff_fields(input res_t e, input res_t g);
    string s;
    s = "";
    if (e.slot_index   !== g.slot_index)   s = {s, " slot_index"};
    if (e.entry_tag    !== g.entry_tag)    s = {s, " entry_tag"};
    if (e.first_value  !== g.first_value)  s = {s, " first_value"};
    if (e.second_value !== g.second_value) s = {s, " second_value"};
    if (e.data_byte    !== g.data_byte)    s = {s, " data_byte"};
    if (e.data_valid   !== g.data_valid)   s = {s, " data_valid"};
    if (e.entry_done   !== g.entry_done)   s = {s, " entry_done"};
    if (e.unknown_tag  !== g.unknown_tag)  s = {s, " unknown_tag"};
    if (e.pool_last    !== g.pool_last)    s = {s, " pool_last"};
    return s;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input logic [7:0] b, input row_e kind, input res_t fixed);
    int unsigned gap;
    bit          active;
    bit          emitted;
    res_t        rec;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    active = !pp_done && pp_slot < pool_size;
    parse_byte(b, emitted, rec);
    if (active) bytes_parsed++;
    case (kind)
      ROW_PREDICT: if (emitted) awaited_records.push_back(rec);
      ROW_FIXED:   awaited_records.push_back(fixed);
      default:     ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_random_byte();
    send_item(8'($urandom_range(0, 255)), ROW_PREDICT, '0);
  endtask

  // pool_count is written only with the parser drained.
  task automatic load_pool_count(input logic [15:0] v);
    in_valid_i <= 1'b0;
    while (awaited_records.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    pool_size = v;
    restart_parse();
    settings_used++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A well-formed entry with random content; now and then an unknown tag.
  task automatic send_entry();
    logic [7:0]  tag;
    bit          known;
    int unsigned total;
    int unsigned split;
    int unsigned len;
    int unsigned r;
    r   = $urandom_range(0, 9);
    tag = (r == 0) ? 8'($urandom_range(0, 255)) : known_tags[$urandom_range(0, 13)];
    send_item(tag, ROW_PREDICT, '0);
    entry_layout(tag, known, total, split);
    if (!known) return;
    if (tag == TAG_UTF8) begin
      r   = $urandom_range(0, 19);
      len = (r < 16) ? $urandom_range(0, 6) :
            (r < 19) ? $urandom_range(7, 20) : $urandom_range(21, 40);
      send_item(8'(len >> 8), ROW_PREDICT, '0);
      send_item(8'(len), ROW_PREDICT, '0);
      repeat (len) send_random_byte();
    end else begin
      repeat (total) send_random_byte();
    end
  endtask

  // Result side: random stall, changed only at the falling edge.
  always @(negedge clk_i) begin
    if (stall_left != 0) stall_left--;
    else stall_left = pick_gap();
    out_stall_i <= (stall_left != 0);
  end

  // Result checker
  always @(posedge clk_i) begin
    res_t  got;
    res_t  want;
    string diff;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {slot_index_o, entry_tag_o, first_value_o, second_value_o, data_byte_o,
             data_valid_o, entry_done_o, unknown_tag_o, pool_last_o};
      if (awaited_records.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX) $display("unexpected record: %s", fmt_rec(got));
      end else begin
        want = awaited_records.pop_front();
        diff = diff_fields(want, got);
        records_checked++;
        if (diff != "") begin
          failures++;
          if (failures <= REPORT_MAX) begin
            $display("mismatch in%s", diff);
            $display("  exp %s", fmt_rec(want));
            $display("  got %s", fmt_rec(got));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records outstanding", cycles,
               awaited_records.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    step_t       plan[$];
    logic [15:0] size;
    int unsigned budget;
    int unsigned r;

    pool_size = 16'd1;
    restart_parse();

    // After reset pool_count is 1: nothing parses.
    plan.push_back('{ROW_QUIET, 16'h07, '0});
    plan.push_back('{ROW_QUIET, 16'hFF, '0});
    // pool_count 0 is empty as well
    plan.push_back('{ROW_CFG, 16'h0000, '0});
    plan.push_back('{ROW_QUIET, 16'h01, '0});
    // widest pool: unknown tags at both byte extremes
    plan.push_back('{ROW_CFG, 16'hFFFF, '0});
    plan.push_back('{ROW_FIXED, 16'h00, mk_rec(16'd1, 8'h00, '0, '0, 1'b1, 1'b1, 1'b0)});
    plan.push_back('{ROW_FIXED, 16'hFF, mk_rec(16'd2, 8'hFF, '0, '0, 1'b1, 1'b1, 1'b0)});
    // empty Utf8 completes on its second length byte
    plan.push_back('{ROW_QUIET, 16'(TAG_UTF8), '0});
    plan.push_back('{ROW_QUIET, 16'h00, '0});
    plan.push_back('{ROW_FIXED, 16'h00, mk_rec(16'd3, TAG_UTF8, '0, '0, 1'b1, 1'b0, 1'b0)});
    // two-byte Utf8 body
    plan.push_back('{ROW_PREDICT, 16'(TAG_UTF8), '0});
    plan.push_back('{ROW_PREDICT, 16'h00, '0});
    plan.push_back('{ROW_PREDICT, 16'h02, '0});
    plan.push_back('{ROW_PREDICT, 16'h41, '0});
    plan.push_back('{ROW_PREDICT, 16'h42, '0});
    // Long in the only slot still completes and ends the pool
    plan.push_back('{ROW_CFG, 16'h0002, '0});
    plan.push_back('{ROW_QUIET, 16'(TAG_LONG), '0});
    repeat (4) plan.push_back('{ROW_QUIET, 16'hFF, '0});
    repeat (3) plan.push_back('{ROW_QUIET, 16'h00, '0});
    plan.push_back('{ROW_FIXED, 16'h00,
                     mk_rec(16'd1, TAG_LONG, 32'hFFFF_FFFF, '0, 1'b1, 1'b0, 1'b1)});
    // finished pool ignores further bytes
    plan.push_back('{ROW_QUIET, 16'h3C, '0});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) load_pool_count(plan[i].value);
      else send_item(plan[i].value[7:0], plan[i].kind, plan[i].rec);
    end

    // Random pools: mostly well-formed entries, some stray bytes that break framing.
    while (bytes_parsed < ITEM_GOAL) begin
      r = $urandom_range(0, 19);
      case (r)
        0:       size = 16'd1;
        1:       size = 16'd0;
        2:       size = 16'd2;
        3:       size = 16'hFFFF;
        4:       size = 16'($urandom_range(0, 65535));
        default: size = 16'($urandom_range(3, 24));
      endcase
      calm = ($urandom_range(0, 3) == 0);
      load_pool_count(size);
      budget = bytes_parsed + $urandom_range(40, 160);
      while (!pp_done && pp_slot < pool_size && bytes_parsed < budget) begin
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) send_random_byte();
        else send_entry();
      end
      repeat ($urandom_range(1, 3)) send_random_byte();
    end

    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (awaited_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_records.size() != 0) begin
      failures += awaited_records.size();
      $display("%0d records never arrived", awaited_records.size());
    end

    $display("parsed %0d stream bytes under %0d pool_count settings", bytes_parsed,
             settings_used);
    $display("checked %0d records, %0d failures", records_checked, failures);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
